// ----- rtl/pms_pkg.sv -----
// Shared types and constants of the periodic message scheduler.
`timescale 1ns / 1ps
package pms_pkg;

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SEND     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_NOTFOUND = 2'd2,
    KIND_RSVD     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_SEND,
    S_DONE
  } state_t;

  localparam logic       CFG_ENTRIES_IN_USE = 1'b0;
  localparam logic       CFG_MAX_SENDS      = 1'b1;
  localparam logic [4:0] SEND_CAP           = 5'd16;
  localparam int         FOREVER_BIT        = 31;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  entry_slot;
    logic [15:0] message_id;
    logic [15:0] period;
    logic [31:0] timeout;
    logic [31:0] ext_value;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic [31:0] send_ext_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] period;
    logic [31:0] timeout;
    logic [31:0] start_time;
    logic [31:0] count;
    logic [31:0] ext;
  } entry_t;

endpackage

// ----- rtl/pms_div.sv -----
// Iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module pms_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r[15:0], q_r[31]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = 17'd0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      q_nxt   = {q_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- rtl/pms_mem.sv -----
// Entry table memory with one write port and one registered read port.
`timescale 1ns / 1ps
module pms_mem #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output pms_pkg::entry_t       rd_data,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  pms_pkg::entry_t       wr_data
);

  pms_pkg::entry_t mem [ENTRIES];
  pms_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/periodic_message_scheduler.sv -----
// Start and stop search the entries in order; a tick runs the bit-serial divider
// for each active entry that has not expired. One item is worked at a time.
// Results leave through an output register; each result beat waits for the sink.
// Reset is synchronous, active low; it clears control state and the per-entry
// defined and active flags, so no clearing pass runs over the table memory.
`timescale 1ns / 1ps
module periodic_message_scheduler #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pms_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pms_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [8:0] ENTRIES9 = 9'(ENTRIES);

  pms_pkg::state_t    state_r, state_nxt;
  pms_pkg::in_item_t  item_r;
  pms_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [4:0]         in_use_r, max_sends_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [4:0]         sends_r, sends_nxt;
  logic [1:0]         done_kind_r, done_kind_nxt;
  logic [ENTRIES-1:0] active_r, defined_r;

  logic               in_acc, out_free;
  logic [8:0]         n9, idx9, slot9;
  logic               more, slot_ok;
  logic [4:0]         limit;
  pms_pkg::entry_t    rd_raw, ent, wr_word;
  logic               mem_rd_en, mem_wr_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [31:0]        elapsed, q;
  logic [15:0]        per_eff;
  logic               id_match, expired, is_active, due;
  logic               div_start, div_busy, div_done;
  logic               set_active, clr_active;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != pms_pkg::S_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  assign n9    = ({4'd0, in_use_r} > ENTRIES9) ? ENTRIES9 : {4'd0, in_use_r};
  assign idx9  = 9'(idx_r);
  assign more  = (idx9 + 9'd1) < n9;
  assign slot9 = {5'd0, in_data.entry_slot};
  assign slot_ok = slot9 < ENTRIES9;
  assign limit = (max_sends_r == 5'd0) ? 5'd1 :
                 (max_sends_r > pms_pkg::SEND_CAP) ? pms_pkg::SEND_CAP : max_sends_r;

  always_comb begin
    ent = rd_raw;
    if (!defined_r[idx_r]) begin
      ent.id      = 16'd0;
      ent.period  = 16'd0;
      ent.timeout = 32'd0;
    end
  end

  assign elapsed   = (item_r.current_time >= ent.start_time) ?
                     (item_r.current_time - ent.start_time) :
                     (~ent.start_time + item_r.current_time);
  assign expired   = elapsed > ent.timeout;
  assign per_eff   = (ent.period == 16'd0) ? 16'd1 : ent.period;
  assign id_match  = ent.id == item_r.message_id;
  assign is_active = active_r[idx_r];
  assign due       = q > ent.count;

  pms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (per_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (q)
  );

  pms_mem #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_word)
  );

  assign rd_addr = idx_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pms_pkg::S_IDLE: begin
        if (in_acc) begin
          if (pms_pkg::op_t'(in_data.operation) == pms_pkg::OP_DEFINE) begin
            state_nxt = slot_ok ? pms_pkg::S_READ : pms_pkg::S_DONE;
          end else begin
            state_nxt = (n9 == 9'd0) ? pms_pkg::S_DONE : pms_pkg::S_READ;
          end
        end
      end
      pms_pkg::S_READ: state_nxt = pms_pkg::S_EVAL;
      pms_pkg::S_EVAL: begin
        unique case (pms_pkg::op_t'(item_r.operation))
          pms_pkg::OP_DEFINE: state_nxt = pms_pkg::S_DONE;
          pms_pkg::OP_START, pms_pkg::OP_STOP: begin
            state_nxt = (id_match || !more) ? pms_pkg::S_DONE : pms_pkg::S_READ;
          end
          pms_pkg::OP_TICK: begin
            if (is_active && !expired) begin
              state_nxt = pms_pkg::S_DIV;
            end else begin
              state_nxt = more ? pms_pkg::S_READ : pms_pkg::S_DONE;
            end
          end
          default: state_nxt = pms_pkg::S_DONE;
        endcase
      end
      pms_pkg::S_DIV: begin
        if (div_done) begin
          if (due) begin
            state_nxt = pms_pkg::S_SEND;
          end else begin
            state_nxt = more ? pms_pkg::S_READ : pms_pkg::S_DONE;
          end
        end
      end
      pms_pkg::S_SEND: begin
        if (out_free) begin
          state_nxt = ((sends_r + 5'd1) >= limit || !more) ? pms_pkg::S_DONE
                                                          : pms_pkg::S_READ;
        end
      end
      pms_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = pms_pkg::S_IDLE;
        end
      end
      default: state_nxt = pms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_rd_en     = state_r == pms_pkg::S_READ;
    mem_wr_en     = 1'b0;
    wr_word       = ent;
    div_start     = 1'b0;
    set_active    = 1'b0;
    clr_active    = 1'b0;
    idx_nxt       = idx_r;
    sends_nxt     = sends_r;
    done_kind_nxt = done_kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      pms_pkg::S_IDLE: begin
        if (in_acc) begin
          sends_nxt     = 5'd0;
          done_kind_nxt = pms_pkg::KIND_DONE;
          if (pms_pkg::op_t'(in_data.operation) == pms_pkg::OP_DEFINE) begin
            idx_nxt = slot9[IDX_W-1:0];
          end else begin
            idx_nxt = '0;
            if (n9 == 9'd0 && pms_pkg::op_t'(in_data.operation) != pms_pkg::OP_TICK) begin
              done_kind_nxt = pms_pkg::KIND_NOTFOUND;
            end
          end
        end
      end
      pms_pkg::S_READ: begin
      end
      pms_pkg::S_EVAL: begin
        unique case (pms_pkg::op_t'(item_r.operation))
          pms_pkg::OP_DEFINE: begin
            mem_wr_en       = 1'b1;
            wr_word.id      = item_r.message_id;
            wr_word.period  = item_r.period;
            wr_word.timeout = item_r.timeout;
          end
          pms_pkg::OP_START: begin
            if (id_match) begin
              mem_wr_en          = 1'b1;
              wr_word.start_time = item_r.current_time;
              wr_word.count      = 32'd0;
              wr_word.ext        = item_r.ext_value;
              set_active         = 1'b1;
            end else if (more) begin
              idx_nxt = idx_r + IDX_W'(1);
            end else begin
              done_kind_nxt = pms_pkg::KIND_NOTFOUND;
            end
          end
          pms_pkg::OP_STOP: begin
            if (id_match) begin
              clr_active = 1'b1;
            end else if (more) begin
              idx_nxt = idx_r + IDX_W'(1);
            end else begin
              done_kind_nxt = pms_pkg::KIND_NOTFOUND;
            end
          end
          pms_pkg::OP_TICK: begin
            if (is_active && !expired) begin
              div_start = 1'b1;
            end else begin
              clr_active = is_active;
              if (more) begin
                idx_nxt = idx_r + IDX_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      pms_pkg::S_DIV: begin
        if (div_done) begin
          if (due) begin
            mem_wr_en = 1'b1;
            if (ent.timeout[pms_pkg::FOREVER_BIT]) begin
              wr_word.start_time = item_r.current_time;
              wr_word.count      = 32'd0;
            end else begin
              wr_word.count = q;
            end
          end else if (more) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      pms_pkg::S_SEND: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.kind           = pms_pkg::KIND_SEND;
          out_data_nxt.entry_index    = idx9[3:0];
          out_data_nxt.send_ext_value = ent.ext;
          out_data_nxt.last           = 1'b0;
          sends_nxt                   = sends_r + 5'd1;
          if (more) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      pms_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.kind           = done_kind_r;
          out_data_nxt.entry_index    = 4'd0;
          out_data_nxt.send_ext_value = 32'd0;
          out_data_nxt.last           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pms_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      in_use_r    <= 5'd16;
      max_sends_r <= 5'd16;
      idx_r       <= '0;
      sends_r     <= 5'd0;
      done_kind_r <= pms_pkg::KIND_DONE;
      active_r    <= '0;
      defined_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      sends_r     <= sends_nxt;
      done_kind_r <= done_kind_nxt;
      if (cfg_we) begin
        if (cfg_index == pms_pkg::CFG_ENTRIES_IN_USE) begin
          in_use_r <= cfg_wdata;
        end else begin
          max_sends_r <= cfg_wdata;
        end
      end
      if (set_active) begin
        active_r[idx_r] <= 1'b1;
      end else if (clr_active) begin
        active_r[idx_r] <= 1'b0;
      end
      if (mem_wr_en) begin
        defined_r[idx_r] <= 1'b1;
      end
    end
    if (in_acc) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_send_limit: assert property (@(posedge clk) disable iff (!rst_n)
    sends_r <= pms_pkg::SEND_CAP)
    else $error("send count above cap");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pms_pkg::S_DONE && out_free) |=> (state_r == pms_pkg::S_IDLE && out_valid))
    else $error("closing beat not issued");

  a_div_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> pms_pkg::op_t'(item_r.operation) == pms_pkg::OP_TICK)
    else $error("divider started outside a tick");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the periodic message scheduler.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    pms_pkg::in_item_t item;
    bit                typed;
    pms_pkg::kind_t    kind;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pms_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pms_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [4:0]         cfg_wdata = '0;

  // Shadow of the scheduler table and registers.
  logic [4:0]  sh_in_use;
  logic [4:0]  sh_max_sends;
  logic [15:0] sh_id [16];
  logic [15:0] sh_period [16];
  logic [31:0] sh_timeout [16];
  logic        sh_active [16];
  logic [31:0] sh_start [16];
  logic [31:0] sh_count [16];
  logic [31:0] sh_ext [16];

  pms_pkg::out_item_t pending_results[$];
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  logic [31:0] sim_now = 32'hFFFF_FF80;

  periodic_message_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic pms_pkg::out_item_t make_result(pms_pkg::kind_t k, logic [3:0] idx,
                                                     logic [31:0] ext, logic lst);
    pms_pkg::out_item_t r;
    r.kind = k;
    r.entry_index = idx;
    r.send_ext_value = ext;
    r.last = lst;
    return r;
  endfunction

  function automatic int find_entry(logic [15:0] id);
    int n;
    n = (sh_in_use > 16) ? 16 : sh_in_use;
    for (int i = 0; i < n; i++) begin
      if (sh_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void schedule_item(pms_pkg::in_item_t it,
                                        ref pms_pkg::out_item_t res[$]);
    int n;
    int limit;
    int sends;
    int hit;
    logic [31:0] d;
    logic [31:0] p;
    logic [31:0] q;
    res = {};
    case (pms_pkg::op_t'(it.operation))
      pms_pkg::OP_DEFINE: begin
        sh_id[it.entry_slot] = it.message_id;
        sh_period[it.entry_slot] = it.period;
        sh_timeout[it.entry_slot] = it.timeout;
        res.push_back(make_result(pms_pkg::KIND_DONE, 4'd0, 32'd0, 1'b1));
      end
      pms_pkg::OP_START, pms_pkg::OP_STOP: begin
        hit = find_entry(it.message_id);
        if (hit < 0) begin
          res.push_back(make_result(pms_pkg::KIND_NOTFOUND, 4'd0, 32'd0, 1'b1));
        end else begin
          if (pms_pkg::op_t'(it.operation) == pms_pkg::OP_START) begin
            sh_start[hit] = it.current_time;
            sh_count[hit] = 32'd0;
            sh_ext[hit] = it.ext_value;
            sh_active[hit] = 1'b1;
          end else begin
            sh_active[hit] = 1'b0;
          end
          res.push_back(make_result(pms_pkg::KIND_DONE, 4'd0, 32'd0, 1'b1));
        end
      end
      default: begin
        n = (sh_in_use > 16) ? 16 : sh_in_use;
        limit = (sh_max_sends == 0) ? 1 : ((sh_max_sends > 16) ? 16 : sh_max_sends);
        sends = 0;
        for (int i = 0; i < n; i++) begin
          if (!sh_active[i]) continue;
          if (it.current_time >= sh_start[i]) d = it.current_time - sh_start[i];
          else d = 32'hFFFF_FFFF - sh_start[i] + it.current_time;
          if (d > sh_timeout[i]) begin
            sh_active[i] = 1'b0;
            continue;
          end
          p = (sh_period[i] == 0) ? 32'd1 : {16'd0, sh_period[i]};
          q = d / p;
          if (q > sh_count[i]) begin
            if (sh_timeout[i][31]) begin
              sh_start[i] = it.current_time;
              sh_count[i] = 32'd0;
            end else begin
              sh_count[i] = q;
            end
            res.push_back(make_result(pms_pkg::KIND_SEND, 4'(i), sh_ext[i], 1'b0));
            sends++;
            if (sends >= limit) break;
          end
        end
        res.push_back(make_result(pms_pkg::KIND_DONE, 4'd0, 32'd0, 1'b1));
      end
    endcase
  endfunction

  task automatic drive_item(input pms_pkg::in_item_t it, input bit typed,
                            input pms_pkg::kind_t kind);
    pms_pkg::out_item_t res[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_item(it, res);
    if (typed) pending_results.push_back(make_result(kind, 4'd0, 32'd0, 1'b1));
    else foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == pms_pkg::CFG_ENTRIES_IN_USE) sh_in_use = val;
    else sh_max_sends = val;
  endtask

  task automatic settle_and_configure(input logic [4:0] in_use, input logic [4:0] max_sends);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(pms_pkg::CFG_ENTRIES_IN_USE, in_use);
    write_reg(pms_pkg::CFG_MAX_SENDS, max_sends);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_id();
    if ($urandom_range(99) < 85) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  function automatic pms_pkg::in_item_t random_item();
    pms_pkg::in_item_t it;
    logic [159:0] raw;
    int r;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(pms_pkg::in_item_t)-1:0];
    r = $urandom_range(99);
    if (r < 15) begin
      it.operation = pms_pkg::OP_DEFINE;
      it.message_id = pick_id();
      if ($urandom_range(9) != 0) it.period = 16'($urandom_range(6));
      r = $urandom_range(9);
      if (r < 4) it.timeout = {1'b1, 31'($urandom_range(50))};
      else if (r < 9) it.timeout = 32'($urandom_range(60));
    end else if (r < 45) begin
      it.operation = pms_pkg::OP_START;
      it.message_id = pick_id();
      it.current_time = sim_now;
    end else if (r < 55) begin
      it.operation = pms_pkg::OP_STOP;
      it.message_id = pick_id();
    end else begin
      it.operation = pms_pkg::OP_TICK;
      if ($urandom_range(99) < 3) sim_now = $urandom;
      else sim_now = sim_now + 32'($urandom_range(4));
      it.current_time = sim_now;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_data));
        end else begin
          if (out_data.kind != pending_results[0].kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_data.kind,
                                      pending_results[0].kind));
          if (out_data.entry_index != pending_results[0].entry_index)
            report_mismatch($sformatf("entry_index %0d, want %0d", out_data.entry_index,
                                      pending_results[0].entry_index));
          if (out_data.send_ext_value != pending_results[0].send_ext_value)
            report_mismatch($sformatf("send_ext_value %h, want %h",
                                      out_data.send_ext_value,
                                      pending_results[0].send_ext_value));
          if (out_data.last != pending_results[0].last)
            report_mismatch($sformatf("last %0d, want %0d", out_data.last,
                                      pending_results[0].last));
          void'(pending_results.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[periodic_message_scheduler] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    pms_pkg::in_item_t it;
    logic [4:0] phase_in_use [5];
    logic [4:0] phase_sends [5];
    int phase_items [5];

    phase_in_use = '{5'd16, 5'd31, 5'd9, 5'd0, 5'd16};
    phase_sends = '{5'd16, 5'd0, 5'd3, 5'd31, 5'd2};
    phase_items = '{60, 60, 50, 30, 50};

    for (int i = 0; i < 16; i++) begin
      sh_id[i] = '0; sh_period[i] = '0; sh_timeout[i] = '0; sh_active[i] = 1'b0;
      sh_start[i] = '0; sh_count[i] = '0; sh_ext[i] = '0;
    end
    sh_in_use = 5'd16;
    sh_max_sends = 5'd16;

    rows = '{
      '{'{pms_pkg::OP_TICK, 4'd0, 16'h0000, 16'd0, 32'd0, 32'd0, 32'h0000_0000}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_START, 4'd0, 16'h1234, 16'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_NOTFOUND},
      '{'{pms_pkg::OP_STOP, 4'd0, 16'hFFFF, 16'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_NOTFOUND},
      '{'{pms_pkg::OP_DEFINE, 4'd0, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_DEFINE, 4'd15, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 32'd0, 32'd0},
        1'b1, pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_DEFINE, 4'd1, 16'h0001, 16'd3, 32'd20, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_DEFINE, 4'd2, 16'h0001, 16'd1, 32'h8000_0005, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_START, 4'd0, 16'h0001, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0},
        1'b1, pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_START, 4'd0, 16'hFFFF, 16'd0, 32'd0, 32'hA5A5_A5A5, 32'hFFFF_FFF0},
        1'b1, pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFF2}, 1'b0,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFF8}, 1'b0,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'h0000_0002}, 1'b0,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_STOP, 4'd0, 16'h0001, 16'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_START, 4'd0, 16'h0001, 16'd0, 32'd0, 32'h0000_0001, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd40}, 1'b0,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_START, 4'd0, 16'h0000, 16'd0, 32'd0, 32'h5A5A_5A5A, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd5}, 1'b0,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_STOP, 4'd0, 16'h0000, 16'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_STOP, 4'd0, 16'hFFFF, 16'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        pms_pkg::KIND_DONE},
      '{'{pms_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}, 1'b0,
        pms_pkg::KIND_DONE}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph < 2) ? 21 : ((ph == 2) ? 57 : 0);
      sink_stall_pct = (ph < 2) ? 57 : ((ph == 2) ? 21 : 0);
      settle_and_configure(phase_in_use[ph], phase_sends[ph]);
      if (ph == 0) begin
        foreach (rows[i]) drive_item(rows[i].item, rows[i].typed, rows[i].kind);
      end
      for (int n = 0; n < phase_items[ph]; n++) begin
        it = random_item();
        drive_item(it, 1'b0, pms_pkg::KIND_DONE);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[periodic_message_scheduler] OK");
    end else begin
      $display("[periodic_message_scheduler] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pms_pkg.sv
rtl/pms_div.sv
rtl/pms_mem.sv
rtl/periodic_message_scheduler.sv
sim/tb_top.sv
